FILE: hw/rtl/cbsc_pkg.sv
// Shared types and constants for the capacitor bank switch controller.
package cbsc_pkg;

  // Control mode codes.
  localparam logic [1:0] MODE_MANUAL   = 2'd0;
  localparam logic [1:0] MODE_VAR      = 2'd1;
  localparam logic [1:0] MODE_VOLT     = 2'd2;
  localparam logic [1:0] MODE_COMBINED = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BANK_LEVEL       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENSE_PHASES     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONNECTED_PHASES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SET_HIGH         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SET_LOW          = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_DELAY     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_TICKS      = 3'd7;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TICK_W     = 31;
  localparam int unsigned SENSE_W    = 32;
  localparam int unsigned NPH        = 3;

  typedef struct packed {
    logic [TICK_W-1:0]         elapsed_ticks;
    logic signed [SENSE_W-1:0] sense_a;
    logic signed [SENSE_W-1:0] sense_b;
    logic signed [SENSE_W-1:0] sense_c;
    logic [NPH-1:0]            manual_cmd;
    logic [NPH-1:0]            manual_cmd_valid;
  } in_item_t;

  typedef struct packed {
    logic [NPH-1:0]    switch_closed;
    logic              wake_pending;
    logic [TICK_W-1:0] wake_after;
  } out_item_t;

  // Configuration as seen by the update logic.
  typedef struct packed {
    logic [1:0]                control_mode;
    logic                      bank_level;
    logic [3:0]                sense_phases;
    logic [NPH-1:0]            connected_phases;
    logic signed [SENSE_W-1:0] set_high;
    logic signed [SENSE_W-1:0] set_low;
    logic [TICK_W-1:0]         change_delay;
    logic [TICK_W-1:0]         dwell_ticks;
  } cfg_t;

  // Threshold decisions of all phase lanes.
  typedef struct packed {
    logic [NPH-1:0] close_req;
    logic [NPH-1:0] open_req;
  } lane_flags_t;

endpackage

FILE: hw/rtl/cbsc_lane.sv
// One phase lane: compares a sensed value against both hysteresis thresholds.
module cbsc_lane (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [cbsc_pkg::SENSE_W-1:0] sense,
  input  logic signed [cbsc_pkg::SENSE_W-1:0] set_low,
  input  logic signed [cbsc_pkg::SENSE_W-1:0] set_high,
  output logic                               close_r,
  output logic                               open_r
);
  import cbsc_pkg::*;

  logic close_nxt;
  logic open_nxt;

  assign close_nxt = (set_low >= sense);
  assign open_nxt  = (set_high <= sense);

  always_ff @(posedge clk) begin
    if (en) begin
      close_r <= close_nxt;
      open_r  <= open_nxt;
    end
  end

endmodule

FILE: hw/rtl/cbsc_merge.sv
// Merging stage: timers, manual overrides and switch state update from the lane flags.
module cbsc_merge #(
  parameter int TIMER_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  cbsc_pkg::cfg_t               cfg,
  input  cbsc_pkg::lane_flags_t        flags,
  input  logic [cbsc_pkg::TICK_W-1:0]  elapsed,
  input  logic [cbsc_pkg::NPH-1:0]     cmd,
  input  logic [cbsc_pkg::NPH-1:0]     cmd_valid,
  output cbsc_pkg::out_item_t          result
);
  import cbsc_pkg::*;

  localparam int TW = TIMER_WIDTH;
  localparam int XW = ((TW > 32) ? TW : 32) + 2;
  localparam logic signed [TW-1:0] TMR_MIN = {1'b1, {(TW-1){1'b0}}};
  localparam logic signed [TW-1:0] TMR_MAX = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [XW-1:0] TMR_MIN_X = {{(XW-TW+1){1'b1}}, {(TW-1){1'b0}}};
  localparam logic signed [XW-1:0] TMR_MAX_X = {{(XW-TW+1){1'b0}}, {(TW-1){1'b1}}};
  localparam logic signed [XW-1:0] WAKE_MAX_X = {{(XW-TICK_W){1'b0}}, {TICK_W{1'b1}}};

  logic [NPH-1:0]       act_r, nxt_st_r, prv_r, req_r;
  logic [NPH-1:0]       act_nxt, nxt_st_nxt, prv_nxt, req_nxt;
  logic signed [TW-1:0] chg_r, dwl_r, chg_nxt, dwl_nxt;

  function automatic logic signed [TW-1:0] tmr_sub(input logic signed [TW-1:0] t,
                                                  input logic [TICK_W-1:0] e);
    logic signed [XW-1:0] d;
    d = {{(XW-TW){t[TW-1]}}, t} - {{(XW-TICK_W){1'b0}}, e};
    if (d < TMR_MIN_X) return TMR_MIN;
    return d[TW-1:0];
  endfunction

  function automatic logic signed [TW-1:0] tmr_load(input logic [TICK_W-1:0] v);
    logic signed [XW-1:0] vx;
    vx = {{(XW-TICK_W){1'b0}}, v};
    if (vx > TMR_MAX_X) return TMR_MAX;
    return vx[TW-1:0];
  endfunction

  function automatic logic tmr_done(input logic signed [TW-1:0] t);
    return t[TW-1] || (t == '0);
  endfunction

  logic [NPH-1:0]       sel;
  logic [NPH-1:0]       diff;
  logic                 active;
  logic signed [TW-1:0] wa_t;
  logic signed [XW-1:0] wa_x;

  // Line-to-line sensing needs both phases of a pair: A uses AB, B uses BC, C uses CA.
  always_comb begin
    if (cfg.sense_phases[3]) begin
      sel[0] = cfg.sense_phases[0] & cfg.sense_phases[1];
      sel[1] = cfg.sense_phases[1] & cfg.sense_phases[2];
      sel[2] = cfg.sense_phases[2] & cfg.sense_phases[0];
    end else begin
      sel = cfg.sense_phases[2:0];
    end
  end

  always_comb begin
    active     = (cfg.control_mode != MODE_MANUAL);
    chg_nxt    = tmr_sub(chg_r, elapsed);
    dwl_nxt    = tmr_sub(dwl_r, elapsed);
    nxt_st_nxt = nxt_st_r;
    prv_nxt    = prv_r;
    req_nxt    = req_r;
    act_nxt    = (act_r & ~cmd_valid) | (cmd & cmd_valid);
    diff       = act_nxt ^ prv_r;

    // In manual mode a hand-made change becomes the next state and waits out the delay.
    if (!active && (diff != '0)) begin
      nxt_st_nxt = (nxt_st_nxt & ~diff) | (act_nxt & diff);
      act_nxt    = (act_nxt & ~diff) | (prv_r & diff);
      chg_nxt    = tmr_load(cfg.change_delay);
    end

    if (tmr_done(chg_nxt)) begin
      act_nxt = (act_nxt & ~cfg.connected_phases) | (nxt_st_nxt & cfg.connected_phases);
      if (!active) begin
        prv_nxt = nxt_st_nxt;
      end else if (cfg.control_mode == MODE_VAR || cfg.control_mode == MODE_VOLT) begin
        for (int i = 0; i < NPH; i++) begin
          if (sel[i]) begin
            if (flags.close_req[i]) req_nxt[i] = 1'b1;
            else if (flags.open_req[i]) req_nxt[i] = 1'b0;
          end
        end
      end
      if (active && (prv_nxt != req_nxt)) begin
        dwl_nxt = tmr_load(cfg.dwell_ticks);
        prv_nxt = req_nxt;
      end
      if (active && tmr_done(dwl_nxt)) nxt_st_nxt = req_nxt;
      if (cfg.bank_level) begin
        nxt_st_nxt = ((nxt_st_nxt & sel) != '0) ? {NPH{1'b1}} : '0;
        if (active) req_nxt = nxt_st_nxt;
        prv_nxt = nxt_st_nxt;
      end
      if (act_nxt != nxt_st_nxt) chg_nxt = tmr_load(cfg.change_delay);
      else chg_nxt = '1;
    end

    if (!tmr_done(dwl_nxt)) wa_t = dwl_nxt;
    else if (!tmr_done(chg_nxt)) wa_t = chg_nxt;
    else wa_t = '0;
    wa_x = {{(XW-TW){wa_t[TW-1]}}, wa_t};
    if (wa_x > WAKE_MAX_X) wa_x = WAKE_MAX_X;

    result.switch_closed = act_nxt;
    result.wake_pending  = (wa_t != '0);
    result.wake_after    = wa_x[TICK_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= '0;
      nxt_st_r <= '0;
      prv_r    <= '0;
      req_r    <= '0;
      chg_r    <= '0;
      dwl_r    <= '0;
    end else if (en) begin
      act_r    <= act_nxt;
      nxt_st_r <= nxt_st_nxt;
      prv_r    <= prv_nxt;
      req_r    <= req_nxt;
      chg_r    <= chg_nxt;
      dwl_r    <= dwl_nxt;
    end
  end

endmodule

FILE: hw/rtl/capacitor_bank_switch_controller_unit.sv
// Top level of the three-phase capacitor bank switch controller.
//
//   Channel | Ports                               | Carries
//   --------+-------------------------------------+---------------------------------
//   input   | in_valid, in_ready, in_data         | one control update (in_item_t)
//   result  | out_valid, out_ready, out_data      | switch states and wake time
//   config  | cfg_we, cfg_index, cfg_wdata        | one register write per cycle
//
// In an update, the three phase lanes first register their threshold
// compares, then the merge stage updates timers and states and loads the output
// register. A new update is taken every cycle while the result side keeps up.
// Reset is synchronous and returns all states to open and both timers to zero.
// A stalled result holds both stages; in_ready drops only while both are full.
module capacitor_bank_switch_controller_unit #(
  parameter int TIMER_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  cbsc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cbsc_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [cbsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbsc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import cbsc_pkg::*;

  cfg_t        cfg_r;
  lane_flags_t flags;
  out_item_t   result;
  out_item_t   out_data_r;
  logic        s1_valid_r;
  logic        out_valid_r;
  logic        advance;
  logic        in_xfer;
  logic [TICK_W-1:0] s1_elapsed_r;
  logic [NPH-1:0]    s1_cmd_r;
  logic [NPH-1:0]    s1_cmd_valid_r;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.control_mode     <= MODE_MANUAL;
      cfg_r.bank_level       <= 1'b0;
      cfg_r.sense_phases     <= 4'd1;
      cfg_r.connected_phases <= {NPH{1'b1}};
      cfg_r.set_high         <= '0;
      cfg_r.set_low          <= '0;
      cfg_r.change_delay     <= '0;
      cfg_r.dwell_ticks      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CONTROL_MODE:     cfg_r.control_mode     <= cfg_wdata[1:0];
        REG_BANK_LEVEL:       cfg_r.bank_level       <= cfg_wdata[0];
        REG_SENSE_PHASES:     cfg_r.sense_phases     <= cfg_wdata[3:0];
        REG_CONNECTED_PHASES: cfg_r.connected_phases <= cfg_wdata[NPH-1:0];
        REG_SET_HIGH:         cfg_r.set_high         <= cfg_wdata;
        REG_SET_LOW:          cfg_r.set_low          <= cfg_wdata;
        REG_CHANGE_DELAY:     cfg_r.change_delay     <= cfg_wdata[TICK_W-1:0];
        REG_DWELL_TICKS:      cfg_r.dwell_ticks      <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  cbsc_lane u_lane_a (
    .clk(clk), .en(in_xfer), .sense(in_data.sense_a),
    .set_low(cfg_r.set_low), .set_high(cfg_r.set_high),
    .close_r(flags.close_req[0]), .open_r(flags.open_req[0])
  );
  cbsc_lane u_lane_b (
    .clk(clk), .en(in_xfer), .sense(in_data.sense_b),
    .set_low(cfg_r.set_low), .set_high(cfg_r.set_high),
    .close_r(flags.close_req[1]), .open_r(flags.open_req[1])
  );
  cbsc_lane u_lane_c (
    .clk(clk), .en(in_xfer), .sense(in_data.sense_c),
    .set_low(cfg_r.set_low), .set_high(cfg_r.set_high),
    .close_r(flags.close_req[2]), .open_r(flags.open_req[2])
  );

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_elapsed_r   <= in_data.elapsed_ticks;
      s1_cmd_r       <= in_data.manual_cmd;
      s1_cmd_valid_r <= in_data.manual_cmd_valid;
    end
  end

  cbsc_merge #(.TIMER_WIDTH(TIMER_WIDTH)) u_merge (
    .clk(clk),
    .rst_n(rst_n),
    .en(s1_valid_r && advance),
    .cfg(cfg_r),
    .flags(flags),
    .elapsed(s1_elapsed_r),
    .cmd(s1_cmd_r),
    .cmd_valid(s1_cmd_valid_r),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (advance) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_idle_wake_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.wake_pending == (out_data_r.wake_after != '0)))
    else $error("wake_pending disagrees with wake_after");

  a_no_block_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled although the result side is ready");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("accepted update did not reach the lane stage");

endmodule
